FILE: design/vke_pkg.sv
// shared types, codes and character classification for the variant key encoder
// no dependencies
package vke_pkg;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] OP_CHROM = 2'd0;
    localparam logic [1:0] OP_REF   = 2'd1;
    localparam logic [1:0] OP_ALT   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BADCH = 2'd2;

    localparam logic [2:0] CLS_OTHER = 3'd0;
    localparam logic [2:0] CLS_DIGIT = 3'd1;
    localparam logic [2:0] CLS_X     = 3'd2;
    localparam logic [2:0] CLS_Y     = 3'd3;
    localparam logic [2:0] CLS_M     = 3'd4;

    localparam logic [4:0] CODE_STAR = 5'd27;

    localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2  = 32'h1b873593;
    localparam logic [31:0] MIX_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;
    localparam logic [31:0] SEED_K  = 32'h3;

    localparam logic [4:0] CHR_X = 5'd23;
    localparam logic [4:0] CHR_Y = 5'd24;
    localparam logic [4:0] CHR_M = 5'd25;

    // one queued word, classified by the front
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [27:0] position;
        logic        last;
        logic [4:0]  acode;
        logic        bad;
        logic [2:0]  cclass;
    } vke_item_t;

    typedef struct packed {
        logic [QAW:0] count;
        logic         full;
    } vke_qstat_t;

    function automatic logic [2:0] char_class(input logic [7:0] c);
        logic [2:0] r;
        r = CLS_OTHER;
        if (c >= 8'h30 && c <= 8'h39)      r = CLS_DIGIT;
        else if (c == 8'h58 || c == 8'h78) r = CLS_X;
        else if (c == 8'h59 || c == 8'h79) r = CLS_Y;
        else if (c == 8'h4d || c == 8'h6d) r = CLS_M;
        return r;
    endfunction

    // returns {bad, code}
    function automatic logic [5:0] allele_class(input logic [7:0] c);
        logic [7:0] u;
        logic [5:0] r;
        u = c;
        if (c >= 8'h61 && c <= 8'h7a) u = c ^ 8'h20;
        if (u == 8'h2a)                    r = {1'b0, CODE_STAR};
        else if (u >= 8'h41 && u <= 8'h5a) r = {1'b0, 5'(u - 8'h40)};
        else                               r = {1'b1, 5'd0};
        return r;
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int r);
        return (x >> r) | (x << (32 - r));
    endfunction

endpackage

FILE: design/vke_front.sv
// front end: takes input words, classifies each character and queues it
// depends on vke_pkg
module vke_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,
    input  logic [1:0]         s_tuser,
    input  logic               s_tlast,
    output logic               q_valid,
    input  logic               q_ready,
    output vke_pkg::vke_item_t q_item,
    output vke_pkg::vke_qstat_t q_stat
);
    import vke_pkg::*;

    vke_item_t      mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg;
    logic [QAW-1:0] rd_ptr_reg;
    logic [QAW:0]   count_reg;
    vke_item_t      in_item;
    logic [5:0]     acls;
    logic           push;
    logic           pop;

    always_comb
    begin
        acls            = allele_class(s_tdata[7:0]);
        in_item.op      = s_tuser;
        in_item.ch      = s_tdata[7:0];
        in_item.position = s_tdata[35:8];
        in_item.last    = s_tlast;
        in_item.acode   = acls[4:0];
        in_item.bad     = acls[5];
        in_item.cclass  = char_class(s_tdata[7:0]);
    end

    assign s_tready    = (count_reg != (QAW+1)'(QDEPTH));
    assign q_valid     = (count_reg != '0);
    assign q_item      = mem[rd_ptr_reg];
    assign push        = s_tvalid && s_tready;
    assign pop         = q_valid && q_ready;
    assign q_stat.count = count_reg;
    assign q_stat.full = !s_tready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)      count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end

endmodule

FILE: design/vke_back.sv
// back end: sequencer that absorbs queued characters, runs the hash mix
// on 32-bit multipliers and holds the result word; depends on vke_pkg
module vke_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_ready,
    input  vke_pkg::vke_item_t q_item,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [63:0]        m_tdata,
    output logic [1:0]         m_tuser
);
    import vke_pkg::*;

    typedef enum logic [3:0] {
        S_FETCH, S_PRE, S_TAKE, S_END, S_M1, S_M2, S_M3, S_F1, S_F2, S_F3, S_OUT
    } state_t;

    typedef enum logic [2:0] {
        R_ENDREF, R_CHUNK, R_FLUSH, R_SEED, R_LAST
    } ret_t;

    state_t     state_reg;
    ret_t       ret_reg;
    vke_item_t  it_reg;

    logic [7:0]  chrom_count_reg;
    logic        prefix_match_reg;
    logic [7:0]  vfull_reg;
    logic [7:0]  vafter_reg;
    logic [2:0]  first_cls_reg;
    logic [2:0]  fourth_cls_reg;
    logic [15:0] ref_len_reg;
    logic [15:0] alt_len_reg;
    logic [31:0] packed_reg;
    logic [31:0] chunk_reg;
    logic [2:0]  fill_reg;
    logic [31:0] run_hash_reg;
    logic [31:0] ref_hash_reg;
    logic        bad_reg;

    logic [31:0] mk_reg;
    logic [31:0] mh_reg;
    logic [63:0] res_key_reg;
    logic [1:0]  res_status_reg;

    logic        out_valid_reg;
    logic [63:0] out_key_reg;
    logic [1:0]  out_status_reg;

    // combinational helpers
    logic [16:0] total;
    logic        strip;
    logic [2:0]  cls_sel;
    logic [7:0]  val_sel;
    logic [4:0]  chrom5;
    logic [1:0]  status_now;
    logic [31:0] pack_code;
    logic [31:0] mix_res;
    logic [31:0] mix_x;
    logic [31:0] fin;
    logic [7:0]  pfx;
    logic [7:0]  digit;
    logic [31:0] chunk_new;
    logic [2:0]  fill_new;
    logic        take_allele;

    always_comb
    begin
        total   = {1'b0, ref_len_reg} + {1'b0, alt_len_reg};
        strip   = prefix_match_reg && (chrom_count_reg > 8'd3);
        cls_sel = strip ? fourth_cls_reg : first_cls_reg;
        val_sel = strip ? vafter_reg : vfull_reg;
        unique case (cls_sel)
            CLS_DIGIT: chrom5 = val_sel[4:0];
            CLS_X:     chrom5 = CHR_X;
            CLS_Y:     chrom5 = CHR_Y;
            CLS_M:     chrom5 = CHR_M;
            default:   chrom5 = 5'd0;
        endcase
        priority if (ref_len_reg == '0 || alt_len_reg == '0) status_now = ST_EMPTY;
        else if (bad_reg)                                   status_now = ST_BADCH;
        else                                                status_now = ST_OK;
        pack_code = packed_reg | (32'(ref_len_reg - 16'd1) << 29)
                               | (32'(alt_len_reg - 16'd1) << 27);
        mix_x   = rotr32(mh_reg ^ mk_reg, 19);
        mix_res = (mix_x << 2) + mix_x + MIX_ADD;
        fin     = mh_reg ^ (mh_reg >> 16);
        unique case (chrom_count_reg[1:0])
            2'd0:    pfx = 8'h63;
            2'd1:    pfx = 8'h68;
            default: pfx = 8'h72;
        endcase
        digit     = it_reg.ch - 8'h30;
        chunk_new = chunk_reg | (32'(it_reg.acode) << (5'd26 - 5'(5 * fill_reg)));
        fill_new  = fill_reg + 3'd1;
        take_allele = (it_reg.op == OP_ALT) ||
                      (it_reg.op == OP_REF && alt_len_reg == '0);
    end

    assign q_ready  = (state_reg == S_FETCH);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_key_reg;
    assign m_tuser  = out_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_FETCH;
            ret_reg          <= R_CHUNK;
            it_reg           <= '0;
            chrom_count_reg  <= '0;
            prefix_match_reg <= 1'b1;
            vfull_reg        <= '0;
            vafter_reg       <= '0;
            first_cls_reg    <= CLS_OTHER;
            fourth_cls_reg   <= CLS_OTHER;
            ref_len_reg      <= '0;
            alt_len_reg      <= '0;
            packed_reg       <= '0;
            chunk_reg        <= '0;
            fill_reg         <= '0;
            run_hash_reg     <= '0;
            ref_hash_reg     <= '0;
            bad_reg          <= 1'b0;
            mk_reg           <= '0;
            mh_reg           <= '0;
            res_key_reg      <= '0;
            res_status_reg   <= ST_OK;
            out_valid_reg    <= 1'b0;
            out_key_reg      <= '0;
            out_status_reg   <= ST_OK;
        end
        else
        begin
            // in S_OUT the output register is reloaded below instead
            if (out_valid_reg && m_tready && state_reg != S_OUT)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_FETCH:
                begin
                    if (q_valid)
                    begin
                        it_reg    <= q_item;
                        state_reg <= S_PRE;
                    end
                end
                S_PRE:
                begin
                    if (it_reg.op == OP_ALT && alt_len_reg == '0)
                    begin
                        if (fill_reg != '0)
                        begin
                            mk_reg    <= chunk_reg;
                            mh_reg    <= run_hash_reg;
                            ret_reg   <= R_ENDREF;
                            state_reg <= S_M1;
                        end
                        else
                        begin
                            ref_hash_reg <= run_hash_reg;
                            run_hash_reg <= '0;
                            chunk_reg    <= '0;
                            state_reg    <= S_TAKE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_TAKE;
                    end
                end
                S_TAKE:
                begin
                    state_reg <= S_END;
                    if (it_reg.op == OP_CHROM)
                    begin
                        if (chrom_count_reg < 8'd3 && (it_reg.ch | 8'h20) != pfx)
                            prefix_match_reg <= 1'b0;
                        if (chrom_count_reg == 8'd0) first_cls_reg <= it_reg.cclass;
                        if (chrom_count_reg == 8'd3) fourth_cls_reg <= it_reg.cclass;
                        vfull_reg <= 8'((vfull_reg << 3) + (vfull_reg << 1)) + digit;
                        if (chrom_count_reg >= 8'd3)
                            vafter_reg <= 8'((vafter_reg << 3) + (vafter_reg << 1)) + digit;
                        if (chrom_count_reg != 8'hff) chrom_count_reg <= chrom_count_reg + 8'd1;
                    end
                    else if (take_allele)
                    begin
                        if (it_reg.bad) bad_reg <= 1'b1;
                        if (total < 17'd5)
                            packed_reg <= packed_reg |
                                (32'(it_reg.acode) << (5'd22 - 5'(5 * total[2:0])));
                        if (it_reg.op == OP_ALT)
                        begin
                            if (alt_len_reg != 16'hffff) alt_len_reg <= alt_len_reg + 16'd1;
                        end
                        else
                        begin
                            if (ref_len_reg != 16'hffff) ref_len_reg <= ref_len_reg + 16'd1;
                        end
                        if (fill_new == 3'd6)
                        begin
                            mk_reg    <= chunk_new;
                            mh_reg    <= run_hash_reg;
                            chunk_reg <= '0;
                            fill_reg  <= '0;
                            ret_reg   <= R_CHUNK;
                            state_reg <= S_M1;
                        end
                        else
                        begin
                            chunk_reg <= chunk_new;
                            fill_reg  <= fill_new;
                        end
                    end
                end
                S_END:
                begin
                    if (!it_reg.last)
                    begin
                        state_reg <= S_FETCH;
                    end
                    else
                    begin
                        res_status_reg <= status_now;
                        if (status_now != ST_OK)
                        begin
                            res_key_reg <= '0;
                            state_reg   <= S_OUT;
                        end
                        else if (total <= 17'd5)
                        begin
                            res_key_reg <= {chrom5, it_reg.position, pack_code[30:0]};
                            state_reg   <= S_OUT;
                        end
                        else if (fill_reg != '0)
                        begin
                            mk_reg    <= chunk_reg;
                            mh_reg    <= run_hash_reg;
                            ret_reg   <= R_FLUSH;
                            state_reg <= S_M1;
                        end
                        else
                        begin
                            mk_reg    <= SEED_K;
                            mh_reg    <= ref_hash_reg;
                            ret_reg   <= R_SEED;
                            state_reg <= S_M1;
                        end
                    end
                end
                S_M1:
                begin
                    mk_reg    <= mk_reg * MIX_C1;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    mk_reg    <= rotr32(mk_reg, 17) * MIX_C2;
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    unique case (ret_reg)
                        R_ENDREF:
                        begin
                            ref_hash_reg <= mix_res;
                            run_hash_reg <= '0;
                            chunk_reg    <= '0;
                            fill_reg     <= '0;
                            state_reg    <= S_TAKE;
                        end
                        R_CHUNK:
                        begin
                            run_hash_reg <= mix_res;
                            state_reg    <= S_END;
                        end
                        R_FLUSH:
                        begin
                            run_hash_reg <= mix_res;
                            mk_reg       <= SEED_K;
                            mh_reg       <= ref_hash_reg;
                            ret_reg      <= R_SEED;
                            state_reg    <= S_M1;
                        end
                        R_SEED:
                        begin
                            mk_reg    <= run_hash_reg;
                            mh_reg    <= mix_res;
                            ret_reg   <= R_LAST;
                            state_reg <= S_M1;
                        end
                        default:
                        begin
                            mh_reg    <= mix_res;
                            state_reg <= S_F1;
                        end
                    endcase
                end
                S_F1:
                begin
                    mh_reg    <= (mh_reg ^ (mh_reg >> 16)) * FIN_C1;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    mh_reg    <= (mh_reg ^ (mh_reg >> 13)) * FIN_C2;
                    state_reg <= S_F3;
                end
                S_F3:
                begin
                    res_key_reg <= {chrom5, it_reg.position, fin[31:2], 1'b1};
                    state_reg   <= S_OUT;
                end
                default:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_key_reg      <= res_key_reg;
                        out_status_reg   <= res_status_reg;
                        chrom_count_reg  <= '0;
                        prefix_match_reg <= 1'b1;
                        vfull_reg        <= '0;
                        vafter_reg       <= '0;
                        first_cls_reg    <= CLS_OTHER;
                        fourth_cls_reg   <= CLS_OTHER;
                        ref_len_reg      <= '0;
                        alt_len_reg      <= '0;
                        packed_reg       <= '0;
                        chunk_reg        <= '0;
                        fill_reg         <= '0;
                        run_hash_reg     <= '0;
                        ref_hash_reg     <= '0;
                        bad_reg          <= 1'b0;
                        state_reg        <= S_FETCH;
                    end
                end
            endcase
        end
    end

endmodule

FILE: design/variant_key_encoder.sv
// variant key encoder top level: front classifier and queue, back sequencer
// depends on vke_pkg, vke_front, vke_back
//
// usage
// - slave stream takes one character word at a time: chromosome name first,
//   then reference allele, then alternate allele; tuser says which string
// - tlast marks the final character of the record; only then does the
//   master stream deliver one word: tdata the 64-bit key, tuser the status
// - a character passes through the back sequencer's fetch, prepare, absorb and
//   end check states; every sixth allele character adds a hash mix through
//   S_M1 to S_M3 with 32x32 multiplies
// - a record of more than five allele characters ends with up to three
//   mixes and the finalising states S_F1 to S_F3 before the key is ready
// - a four-deep queue between front and back keeps taking words while the
//   back is busy or the result word still waits in the output register
// - when the receiver stalls, the result word holds; the back stops at the
//   next finished record and the queue fills, then s_tready drops
// - reset empties the queue, clears all record state and drops m_tvalid
module variant_key_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // ch [7:0], position [35:8], zero fill
    input  logic [1:0]  s_tuser,   // op [1:0]
    input  logic        s_tlast,   // last character of the record
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // key [63:0]
    output logic [1:0]  m_tuser    // status [1:0]
);
    import vke_pkg::*;

    logic       q_valid;
    logic       q_ready;
    vke_item_t  q_item;
    vke_qstat_t q_stat;

    vke_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .q_stat   (q_stat)
    );

    vke_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // a failed record never carries a key
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != ST_OK |-> m_tdata == 64'd0)
        else $error("key not cleared on failed record");

    // status stays within its defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_BADCH))
        else $error("undefined status code");

    // queue occupancy never passes its depth, and full means no more words
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= (QAW+1)'(QDEPTH) && (q_stat.full == !s_tready))
        else $error("queue occupancy out of range");

endmodule

FILE: dv/tb_variant_key_encoder.sv
// self-checking testbench for the variant key encoder: random character records,
// scoreboard with its own key predictor, random idling and a long receiver stall
// depends on vke_pkg and variant_key_encoder
module tb_variant_key_encoder;
    import vke_pkg::*;

    // one expected result word
    typedef struct {
        logic [63:0] key;
        logic [1:0]  status;
    } key_word_t;

    // predictor of the key with its own record state, plus the queue of keys owed
    class key_scoreboard;
        logic [7:0]  n_chrom;
        logic        chr_prefix;
        logic [7:0]  val_all;
        logic [7:0]  val_tail;
        logic [2:0]  cls_first;
        logic [2:0]  cls_fourth;
        logic [15:0] len_ref;
        logic [15:0] len_alt;
        logic [31:0] packed_codes;
        logic [31:0] chunk;
        logic [2:0]  chunk_n;
        logic [31:0] hash;
        logic [31:0] hash_ref;
        logic        bad_seen;
        key_word_t   owed[$];
        int          errors;
        int          mismatches;

        function new();
            errors = 0;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            n_chrom = 0;
            chr_prefix = 1;
            val_all = 0;
            val_tail = 0;
            cls_first = CLS_OTHER;
            cls_fourth = CLS_OTHER;
            len_ref = 0;
            len_alt = 0;
            packed_codes = 0;
            chunk = 0;
            chunk_n = 0;
            hash = 0;
            hash_ref = 0;
            bad_seen = 0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int r);
            return (x >> r) | (x << (32 - r));
        endfunction

        function logic [31:0] mix(logic [31:0] k, logic [31:0] h);
            k = k * MIX_C1;
            k = ror(k, 17);
            k = k * MIX_C2;
            h = h ^ k;
            h = ror(h, 19);
            return h * 32'd5 + MIX_ADD;
        endfunction

        function logic [2:0] classify(logic [7:0] c);
            if (c >= "0" && c <= "9") return CLS_DIGIT;
            if (c == "X" || c == "x") return CLS_X;
            if (c == "Y" || c == "y") return CLS_Y;
            if (c == "M" || c == "m") return CLS_M;
            return CLS_OTHER;
        endfunction

        function void flush();
            if (chunk_n != 0)
                hash = mix(chunk, hash);
            chunk = 0;
            chunk_n = 0;
        endfunction

        function void add_chrom(logic [7:0] c);
            logic [7:0] pfx;
            pfx = (n_chrom == 0) ? "c" : (n_chrom == 1) ? "h" : "r";
            if (n_chrom < 3 && (c | 8'h20) != pfx)
                chr_prefix = 0;
            if (n_chrom == 0)
                cls_first = classify(c);
            if (n_chrom == 3)
                cls_fourth = classify(c);
            val_all = val_all * 8'd10 + (c - 8'h30);
            if (n_chrom >= 3)
                val_tail = val_tail * 8'd10 + (c - 8'h30);
            if (n_chrom != 8'hff)
                n_chrom++;
        endfunction

        function void add_allele(logic [7:0] c, bit is_alt);
            logic [31:0] code;
            int          idx;
            idx = len_ref + len_alt;
            if (c >= "a" && c <= "z")
                c = c ^ 8'h20;
            if (c == "*")
                code = CODE_STAR;
            else if (c >= "A" && c <= "Z")
                code = c - 8'h40;
            else
            begin
                code = 0;
                bad_seen = 1;
            end
            if (idx < 5)
                packed_codes |= code << (22 - 5 * idx);
            chunk |= code << (26 - 5 * chunk_n);
            chunk_n++;
            if (chunk_n == 6)
                flush();
            if (is_alt)
            begin
                if (len_alt != 16'hffff) len_alt++;
            end
            else if (len_ref != 16'hffff)
                len_ref++;
        endfunction

        function logic [4:0] chrom_code();
            bit         strip;
            logic [2:0] cls;
            logic [7:0] v;
            strip = chr_prefix && n_chrom > 3;
            cls = strip ? cls_fourth : cls_first;
            v = strip ? val_tail : val_all;
            case (cls)
                CLS_DIGIT: return v[4:0];
                CLS_X:     return CHR_X;
                CLS_Y:     return CHR_Y;
                CLS_M:     return CHR_M;
                default:   return 5'd0;
            endcase
        endfunction

        function logic [30:0] allele_code();
            logic [31:0] h;
            logic [31:0] lr;
            logic [31:0] la;
            if (len_ref + len_alt <= 5)
            begin
                lr = len_ref - 1;
                la = len_alt - 1;
                h = packed_codes | (lr << 29) | (la << 27);
                return h[30:0];
            end
            flush();
            h = mix(hash, mix(SEED_K, hash_ref));
            h ^= h >> 16;
            h = h * FIN_C1;
            h ^= h >> 13;
            h = h * FIN_C2;
            h ^= h >> 16;
            h = (h >> 1) | 32'h1;
            return h[30:0];
        endfunction

        // note an accepted character word, queue a key if it ends the record
        function void note_word(logic [1:0] op, logic [7:0] c, logic [27:0] pos, logic lst);
            key_word_t w;
            if (op == OP_CHROM)
                add_chrom(c);
            else if (op == OP_REF)
            begin
                if (len_alt == 0) add_allele(c, 0);
            end
            else if (op == OP_ALT)
            begin
                if (len_alt == 0)
                begin
                    flush();
                    hash_ref = hash;
                    hash = 0;
                end
                add_allele(c, 1);
            end
            if (!lst)
                return;
            w.key = 0;
            if (len_ref == 0 || len_alt == 0)
                w.status = ST_EMPTY;
            else if (bad_seen)
                w.status = ST_BADCH;
            else
                w.status = ST_OK;
            if (w.status == ST_OK)
                w.key = {chrom_code(), pos, allele_code()};
            owed.push_back(w);
            clear();
        endfunction

        // compare one result word with the oldest key owed
        function void check_word(logic [63:0] key, logic [1:0] status);
            key_word_t w;
            if (owed.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected result key %h status %0d", key, status);
                return;
            end
            w = owed.pop_front();
            if (key !== w.key || status !== w.status)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("mismatch: key exp %h got %h, status exp %0d got %0d",
                             w.key, key, w.status, status);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // ch [7:0], position [35:8], zero fill
    logic [1:0]  s_tuser;   // op [1:0]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // key [63:0]
    logic [1:0]  m_tuser;   // status [1:0]

    key_scoreboard sb;
    bit            stim_done;
    bit            hold_off;    // receiver long stall requested
    int            idle_cycles;

    variant_key_encoder u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 20 unit clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // send one character word: random gap first, then hold until accepted
    task automatic send_char(logic [1:0] op, logic [7:0] c, logic lst);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;    // bursts with no idling
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tlast  <= lst;
        s_tdata  <= {4'd0, 28'($urandom), c};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_string(logic [1:0] op, string s, logic end_rec);
        for (int i = 0; i < s.len(); i++)
            send_char(op, s[i], end_rec && i == s.len() - 1);
    endtask

    task automatic send_record(string chrom, string ra, string aa);
        send_string(OP_CHROM, chrom, 0);
        send_string(OP_REF, ra, 0);
        send_string(OP_ALT, aa, 1);
    endtask

    function automatic logic [7:0] rand_base();
        case ($urandom_range(0, 9))
            0:       return "*";
            1:       return 8'($urandom_range("a", "z"));
            2:       return 8'($urandom);    // mostly bad characters
            default: return 8'($urandom_range("A", "Z"));
        endcase
    endfunction

    function automatic string rand_chrom();
        string s;
        int    n;
        s = "";
        if ($urandom_range(0, 1))
            s = $urandom_range(0, 1) ? "chr" : "CHR";
        case ($urandom_range(0, 5))
            0: s = {s, "X"};
            1: s = {s, "y"};
            2: s = {s, "M"};
            3: s = {s, string'(8'($urandom))};
            default:
            begin
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    s = {s, string'(8'($urandom_range("0", "9")))};
            end
        endcase
        return s;
    endfunction

    function automatic string rand_allele();
        string s;
        int    n;
        s = "";
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 4);
        if ($urandom_range(0, 30) == 0)
            n = 0;
        for (int i = 0; i < n; i++)
            s = {s, string'(rand_base())};
        return s;
    endfunction

    // stimulus
    initial
    begin
        int sent;
        int n;
        sb = new();
        stim_done = 0;
        hold_off = 0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_CHROM;
        s_tlast = 1'b0;
        rst_n = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: prefixes, special chromosomes, packing limits, empty and bad alleles
        send_record("chr1", "A", "T");
        send_record("ChR22", "*", "z");
        send_record("chr", "AC", "G");
        send_record("x", "ACGTA", "");    // no alternate, record runs on into the next
        send_record("9", "ACGT", "A");
        send_record("", "ACGTAC", "GTACGTA");
        send_record("255", "A", "1");
        send_char(OP_REF, "A", 1);        // last on reference string
        send_char(OP_CHROM, "M", 0);
        send_char(OP_REF, "A", 0);
        send_char(OP_ALT, "C", 0);
        send_char(OP_REF, "G", 0);        // late reference ignored
        send_char(2'd3, 8'hff, 1);        // unused op ends the record
        sent = 55;

        while (sent < 1400)
        begin
            if (sent > 600)
                hold_off = 1;
            if ($urandom_range(0, 12) == 0)
            begin
                // noise: random op, character and end flag
                n = $urandom_range(1, 8);
                for (int i = 0; i < n; i++)
                    send_char(2'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
                send_char(OP_ALT, "A", 1);
                sent += n + 1;
            end
            else
            begin
                string c;
                string ra;
                string aa;
                c = rand_chrom();
                ra = rand_allele();
                aa = rand_allele();
                if (aa.len() == 0)
                    aa = "G";
                send_record(c, ra, aa);
                sent += c.len() + ra.len() + aa.len();
            end
        end
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
        stim_done = 1;
    end

    // receiver: random wait before each word, one long hold-off once
    initial
    begin
        bit stalled;
        int gap;
        stalled = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
            if (hold_off && !stalled)
            begin
                stalled = 1;
                gap = 400;    // long hold-off while the sender keeps offering
            end
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // result sampling at the rising edge
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata, m_tuser);

    always @(posedge clk)
        if (rst_n && s_tvalid && s_tready)
            sb.note_word(s_tuser, s_tdata[7:0], s_tdata[35:8], s_tlast);

    // watchdog on cycles with no accepted word, and the end of the run
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 5000)
            begin
                $display("tb_variant_key_encoder: done, errors");
                $finish;
            end
            if (stim_done && sb.owed.size() == 0)
            begin
                repeat (200) @(posedge clk);
                if (sb.errors == 0 && sb.owed.size() == 0)
                    $display("tb_variant_key_encoder: done, clean");
                else
                    $display("tb_variant_key_encoder: done, errors");
                $finish;
            end
        end
    end

endmodule
